>>> rtl/pfn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polygon face normal package
// Shared widths, status codes and controller/datapath command types.
// ----------------------------------------------------------------------------
package pfn_pkg;

	localparam int COORD_WIDTH = 16;
	localparam int MAX_VERTICES = 4;
	localparam int NORMAL_FRAC_BITS = 14;
	localparam int FACE_TRI = 3;
	localparam int OUT_WIDTH = 16;
	localparam int IDX_WIDTH = $clog2(MAX_VERTICES);
	localparam int CNT_WIDTH = 3;
	localparam int DIFF_WIDTH = COORD_WIDTH + 1;
	localparam int DIFF_SHIFT = (COORD_WIDTH > 30) ? COORD_WIDTH - 30 : 0;
	localparam int PROD_WIDTH = 2 * DIFF_WIDTH;
	localparam int CROSS_WIDTH = PROD_WIDTH + 1;
	localparam int MAG_WIDTH = 31;
	localparam int SUM_WIDTH = 64;
	localparam int ROOT_WIDTH = 32;
	localparam int NUM_WIDTH = MAG_WIDTH + NORMAL_FRAC_BITS + 1;
	localparam int QUO_WIDTH = NORMAL_FRAC_BITS + 2;
	localparam int ROOT_STEPS = 32;
	localparam int STEP_WIDTH = 6;

	typedef enum logic [1:0] {
		STATUS_OK = 2'd0,
		STATUS_DEGENERATE = 2'd1,
		STATUS_BAD_COUNT = 2'd2
	} face_status_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_DIFF,
		CMD_MUL,
		CMD_CROSS,
		CMD_NORM,
		CMD_SQUARE,
		CMD_ROOT_INIT,
		CMD_ROOT_STEP,
		CMD_DIV_INIT,
		CMD_DIV_STEP,
		CMD_DIV_SAVE
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic [1:0] comp;
		logic quad_alt;
	} dp_cmd_t;

	typedef struct packed {
		logic degenerate;
	} dp_status_t;

endpackage

>>> rtl/pfn_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polygon face normal channels
// Valid/ready interfaces for the vertex requests and the normal requests.
// ----------------------------------------------------------------------------
interface pfn_vertex_if;
	logic valid;
	logic ready;
	logic signed [pfn_pkg::COORD_WIDTH-1:0] vertex_x;
	logic signed [pfn_pkg::COORD_WIDTH-1:0] vertex_y;
	logic signed [pfn_pkg::COORD_WIDTH-1:0] vertex_z;
	logic last_vertex;
	modport source (output valid, vertex_x, vertex_y, vertex_z, last_vertex, input ready);
	modport sink (input valid, vertex_x, vertex_y, vertex_z, last_vertex, output ready);
endinterface

interface pfn_normal_if;
	logic valid;
	logic ready;
	logic signed [pfn_pkg::OUT_WIDTH-1:0] normal_x;
	logic signed [pfn_pkg::OUT_WIDTH-1:0] normal_y;
	logic signed [pfn_pkg::OUT_WIDTH-1:0] normal_z;
	logic [1:0] face_status;
	modport source (output valid, normal_x, normal_y, normal_z, face_status, input ready);
	modport sink (input valid, normal_x, normal_y, normal_z, face_status, output ready);
endinterface

>>> rtl/pfn_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polygon face normal datapath
// Vertex store, differences, cross product, normalization, bitwise square
// root and restoring divider, stepped by controller commands.
// ----------------------------------------------------------------------------
module pfn_datapath (
	input logic clk,
	input logic store_en,
	input logic [pfn_pkg::IDX_WIDTH-1:0] store_idx,
	input logic [pfn_pkg::COORD_WIDTH-1:0] in_x,
	input logic [pfn_pkg::COORD_WIDTH-1:0] in_y,
	input logic [pfn_pkg::COORD_WIDTH-1:0] in_z,
	input pfn_pkg::dp_cmd_t cmd,
	output pfn_pkg::dp_status_t status,
	output logic quad_collapse,
	output logic [pfn_pkg::OUT_WIDTH-1:0] res_x,
	output logic [pfn_pkg::OUT_WIDTH-1:0] res_y,
	output logic [pfn_pkg::OUT_WIDTH-1:0] res_z
);

	localparam int CW = pfn_pkg::COORD_WIDTH;
	localparam int DW = pfn_pkg::DIFF_WIDTH;
	localparam int PW = pfn_pkg::PROD_WIDTH;
	localparam int XW = pfn_pkg::CROSS_WIDTH;
	localparam int MW = pfn_pkg::MAG_WIDTH;
	localparam int NW = pfn_pkg::NUM_WIDTH;
	localparam int QW = pfn_pkg::QUO_WIDTH;
	localparam int RW = pfn_pkg::ROOT_WIDTH;
	localparam int SW = pfn_pkg::SUM_WIDTH;

	logic [3*CW-1:0] store_q [pfn_pkg::MAX_VERTICES];
	logic signed [DW-1:0] cb_q [3];
	logic signed [DW-1:0] ab_q [3];
	logic signed [PW-1:0] p0_q [3];
	logic signed [PW-1:0] p1_q [3];
	logic [XW-1:0] mg_q [3];
	logic neg_q [3];
	logic [MW-1:0] nm_q [3];
	logic [SW-1:0] sum_q;
	logic [SW-1:0] rem_q;
	logic [RW-1:0] root_q;
	logic [NW-1:0] dnum_q;
	logic [NW-1:0] drem_q;
	logic [QW-1:0] quo_q;
	logic [pfn_pkg::OUT_WIDTH-1:0] res_q [3];

	logic [3*CW-1:0] va, vb, vc;
	logic [XW-1:0] mx;
	logic [5:0] lz;
	logic [SW-1:0] root_trial;
	logic [SW-1:0] root_rem_sh;
	logic [NW-1:0] drem_sh;
	logic [NW-1:0] mag_ext;
	logic [QW-1:0] qsigned;
	logic [SW-1:0] sq;
	logic [1:0] k1, k2;

	assign quad_collapse = (store_q[0] == store_q[1]) || (store_q[1] == store_q[2]);
	assign va = store_q[0];
	assign vb = cmd.quad_alt ? store_q[2] : store_q[1];
	assign vc = cmd.quad_alt ? store_q[3] : store_q[2];

	always_comb begin
		mx = mg_q[0];
		if (mg_q[1] > mx) mx = mg_q[1];
		if (mg_q[2] > mx) mx = mg_q[2];
		lz = '0;
		for (int i = 0; i < XW; i++) begin
			if (mx[i]) lz = 6'(i);
		end
		k1 = (cmd.comp == 2'd0) ? 2'd1 : (cmd.comp == 2'd1) ? 2'd2 : 2'd0;
		k2 = (cmd.comp == 2'd0) ? 2'd2 : (cmd.comp == 2'd1) ? 2'd0 : 2'd1;
		sq = SW'(nm_q[cmd.comp]) * SW'(nm_q[cmd.comp]);
		root_rem_sh = {rem_q[SW-3:0], 2'b00};
		root_trial = SW'({root_q, 2'b01});
		drem_sh = {drem_q[NW-2:0], dnum_q[NW-1]};
		mag_ext = NW'(root_q);
		qsigned = neg_q[cmd.comp] ? (QW'(0) - quo_q) : quo_q;
	end

	assign status.degenerate = (mx == '0);

	always_ff @(posedge clk) begin
		if (store_en) begin
			store_q[store_idx] <= {in_x, in_y, in_z};
		end
		unique case (cmd.op)
			pfn_pkg::CMD_DIFF: begin
				for (int k = 0; k < 3; k++) begin
					cb_q[k] <= (DW'($signed(vc[(2-k)*CW +: CW])) -
						DW'($signed(vb[(2-k)*CW +: CW]))) >>> pfn_pkg::DIFF_SHIFT;
					ab_q[k] <= (DW'($signed(va[(2-k)*CW +: CW])) -
						DW'($signed(vb[(2-k)*CW +: CW]))) >>> pfn_pkg::DIFF_SHIFT;
				end
			end
			pfn_pkg::CMD_MUL: begin
				p0_q[cmd.comp] <= PW'(cb_q[k1]) * PW'(ab_q[k2]);
				p1_q[cmd.comp] <= PW'(cb_q[k2]) * PW'(ab_q[k1]);
			end
			pfn_pkg::CMD_CROSS: begin
				for (int k = 0; k < 3; k++) begin
					logic signed [XW-1:0] c;
					c = XW'(p0_q[k]) - XW'(p1_q[k]);
					neg_q[k] <= c[XW-1];
					mg_q[k] <= c[XW-1] ? (XW'(0) - c) : c;
				end
			end
			pfn_pkg::CMD_NORM: begin
				for (int k = 0; k < 3; k++) begin
					if (lz >= 6'(MW - 1)) begin
						nm_q[k] <= MW'(mg_q[k] >> (lz - 6'(MW - 1)));
					end else begin
						nm_q[k] <= MW'(mg_q[k] << (6'(MW - 1) - lz));
					end
				end
				sum_q <= '0;
			end
			pfn_pkg::CMD_SQUARE: begin
				sum_q <= sum_q + sq;
			end
			pfn_pkg::CMD_ROOT_INIT: begin
				rem_q <= '0;
				root_q <= '0;
			end
			pfn_pkg::CMD_ROOT_STEP: begin
				if ((root_rem_sh | SW'(sum_q[SW-1 -: 2])) >= root_trial) begin
					rem_q <= (root_rem_sh | SW'(sum_q[SW-1 -: 2])) - root_trial;
					root_q <= {root_q[RW-2:0], 1'b1};
				end else begin
					rem_q <= root_rem_sh | SW'(sum_q[SW-1 -: 2]);
					root_q <= {root_q[RW-2:0], 1'b0};
				end
				sum_q <= {sum_q[SW-3:0], 2'b00};
			end
			pfn_pkg::CMD_DIV_INIT: begin
				dnum_q <= (NW'(nm_q[cmd.comp]) << pfn_pkg::NORMAL_FRAC_BITS) +
					NW'(root_q >> 1);
				drem_q <= '0;
				quo_q <= '0;
			end
			pfn_pkg::CMD_DIV_STEP: begin
				dnum_q <= {dnum_q[NW-2:0], 1'b0};
				if (drem_sh >= mag_ext) begin
					drem_q <= drem_sh - mag_ext;
					quo_q <= {quo_q[QW-2:0], 1'b1};
				end else begin
					drem_q <= drem_sh;
					quo_q <= {quo_q[QW-2:0], 1'b0};
				end
			end
			pfn_pkg::CMD_DIV_SAVE: begin
				res_q[cmd.comp] <= pfn_pkg::OUT_WIDTH'(qsigned);
			end
			default: begin
			end
		endcase
	end

	assign res_x = res_q[0];
	assign res_y = res_q[1];
	assign res_z = res_q[2];

endmodule

>>> rtl/pfn_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polygon face normal controller
// Counts vertices, sequences the datapath and holds the output request.
// ----------------------------------------------------------------------------
module pfn_controller (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_last,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	output logic [1:0] out_status,
	output logic out_zero,
	output logic store_en,
	output logic [pfn_pkg::IDX_WIDTH-1:0] store_idx,
	output pfn_pkg::dp_cmd_t cmd,
	input pfn_pkg::dp_status_t status,
	input logic quad_collapse
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIFF,
		ST_MUL,
		ST_CROSS,
		ST_NORM,
		ST_SQUARE,
		ST_ROOT_INIT,
		ST_ROOT,
		ST_DIV_INIT,
		ST_DIV,
		ST_DIV_SAVE,
		ST_OUT
	} state_t;

	state_t state_q;
	logic [pfn_pkg::CNT_WIDTH-1:0] count_q;
	logic [pfn_pkg::CNT_WIDTH-1:0] total;
	logic [1:0] comp_q;
	logic [pfn_pkg::STEP_WIDTH-1:0] step_q;
	logic alt_q;
	logic valid_q;
	logic zero_q;
	logic [1:0] stat_q;
	logic accept;

	assign in_ready = (state_q == ST_IDLE) && !valid_q;
	assign accept = in_valid && in_ready;
	assign store_en = accept && (count_q < pfn_pkg::CNT_WIDTH'(pfn_pkg::MAX_VERTICES));
	assign store_idx = count_q[pfn_pkg::IDX_WIDTH-1:0];
	assign total = (count_q == '1) ? count_q : count_q + 1'b1;
	assign out_valid = valid_q;
	assign out_status = stat_q;
	assign out_zero = zero_q;

	always_comb begin
		cmd.comp = comp_q;
		cmd.quad_alt = alt_q;
		unique case (state_q)
			ST_DIFF: cmd.op = pfn_pkg::CMD_DIFF;
			ST_MUL: cmd.op = pfn_pkg::CMD_MUL;
			ST_CROSS: cmd.op = pfn_pkg::CMD_CROSS;
			ST_NORM: cmd.op = pfn_pkg::CMD_NORM;
			ST_SQUARE: cmd.op = pfn_pkg::CMD_SQUARE;
			ST_ROOT_INIT: cmd.op = pfn_pkg::CMD_ROOT_INIT;
			ST_ROOT: cmd.op = pfn_pkg::CMD_ROOT_STEP;
			ST_DIV_INIT: cmd.op = pfn_pkg::CMD_DIV_INIT;
			ST_DIV: cmd.op = pfn_pkg::CMD_DIV_STEP;
			ST_DIV_SAVE: cmd.op = pfn_pkg::CMD_DIV_SAVE;
			default: cmd.op = pfn_pkg::CMD_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			comp_q <= '0;
			step_q <= '0;
			alt_q <= 1'b0;
			valid_q <= 1'b0;
			zero_q <= 1'b0;
			stat_q <= pfn_pkg::STATUS_OK;
		end else begin
			if (valid_q && out_ready) begin
				valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (!in_last) begin
							count_q <= total;
						end else begin
							count_q <= '0;
							comp_q <= '0;
							if (total == pfn_pkg::CNT_WIDTH'(pfn_pkg::FACE_TRI)) begin
								alt_q <= 1'b0;
								state_q <= ST_DIFF;
							end else if (total ==
								pfn_pkg::CNT_WIDTH'(pfn_pkg::MAX_VERTICES)) begin
								alt_q <= quad_collapse;
								state_q <= ST_DIFF;
							end else begin
								stat_q <= pfn_pkg::STATUS_BAD_COUNT;
								zero_q <= 1'b1;
								valid_q <= 1'b1;
							end
						end
					end
				end
				ST_DIFF: state_q <= ST_MUL;
				ST_MUL: begin
					comp_q <= (comp_q == 2'd2) ? 2'd0 : comp_q + 2'd1;
					if (comp_q == 2'd2) state_q <= ST_CROSS;
				end
				ST_CROSS: state_q <= ST_NORM;
				ST_NORM: begin
					if (status.degenerate) begin
						stat_q <= pfn_pkg::STATUS_DEGENERATE;
						zero_q <= 1'b1;
						valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_SQUARE;
					end
				end
				ST_SQUARE: begin
					comp_q <= (comp_q == 2'd2) ? 2'd0 : comp_q + 2'd1;
					if (comp_q == 2'd2) state_q <= ST_ROOT_INIT;
				end
				ST_ROOT_INIT: begin
					step_q <= '0;
					state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					step_q <= step_q + 1'b1;
					if (step_q == pfn_pkg::STEP_WIDTH'(pfn_pkg::ROOT_STEPS - 1)) begin
						state_q <= ST_DIV_INIT;
					end
				end
				ST_DIV_INIT: begin
					step_q <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == pfn_pkg::STEP_WIDTH'(pfn_pkg::NUM_WIDTH - 1)) begin
						state_q <= ST_DIV_SAVE;
					end
				end
				ST_DIV_SAVE: begin
					comp_q <= (comp_q == 2'd2) ? 2'd0 : comp_q + 2'd1;
					if (comp_q == 2'd2) begin
						stat_q <= pfn_pkg::STATUS_OK;
						zero_q <= 1'b0;
						valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_DIV_INIT;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/polygon_face_normal_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polygon face normal unit
// Collects up to four vertices of a face and returns its unit normal.
// ----------------------------------------------------------------------------
// Channel     Direction  Payload
// vtx         in         vertex_x, vertex_y, vertex_z, last_vertex
// nrm         out        normal_x, normal_y, normal_z, face_status
//
// A vertex that is not the last is counted, and stored if among the first four.
// A last vertex of a valid face raises its request once the face is computed:
// a 32-step square root and three 46-step restoring divides share
// one datapath.
// A degenerate face raises its request once its cross product is zero, a bad
// count in the cycle after the last vertex.
// Input stalls while a face is computed or its request waits on the output.
// Reset clears the vertex count and all control; stored vertices are not cleared.
module polygon_face_normal_unit (
	input logic clk,
	input logic arst_n,
	pfn_vertex_if.sink vtx,
	pfn_normal_if.source nrm
);

	pfn_pkg::dp_cmd_t cmd;
	pfn_pkg::dp_status_t status;
	logic quad_collapse;
	logic store_en;
	logic [pfn_pkg::IDX_WIDTH-1:0] store_idx;
	logic out_zero;
	logic [1:0] out_status;
	logic [pfn_pkg::OUT_WIDTH-1:0] res_x, res_y, res_z;

	pfn_controller u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(vtx.valid), .in_last(vtx.last_vertex), .in_ready(vtx.ready),
		.out_valid(nrm.valid), .out_ready(nrm.ready),
		.out_status(out_status), .out_zero(out_zero),
		.store_en(store_en), .store_idx(store_idx),
		.cmd(cmd), .status(status), .quad_collapse(quad_collapse)
	);

	pfn_datapath u_dp (
		.clk(clk),
		.store_en(store_en), .store_idx(store_idx),
		.in_x(vtx.vertex_x), .in_y(vtx.vertex_y), .in_z(vtx.vertex_z),
		.cmd(cmd), .status(status), .quad_collapse(quad_collapse),
		.res_x(res_x), .res_y(res_y), .res_z(res_z)
	);

	assign nrm.normal_x = out_zero ? '0 : res_x;
	assign nrm.normal_y = out_zero ? '0 : res_y;
	assign nrm.normal_z = out_zero ? '0 : res_z;
	assign nrm.face_status = out_status;

endmodule

>>> rtl/pfn_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polygon face normal checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module pfn_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic in_last,
	input logic out_valid,
	input logic out_ready,
	input logic [1:0] status,
	input logic [15:0] nx,
	input logic [15:0] ny,
	input logic [15:0] nz
);

	a_no_input_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input ready while request pending");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status != 2'd3)) else $error("bad status code");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != 2'd0) |-> (nx == '0 && ny == '0 && nz == '0))
		else $error("failed face with nonzero normal");

	a_nonlast_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !in_last && !out_valid) |=> !out_valid)
		else $error("request without last vertex");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(nx) && $stable(status)))
		else $error("request dropped");

endmodule

bind polygon_face_normal_unit pfn_checker u_pfn_checker (
	.clk(clk), .arst_n(arst_n),
	.in_valid(vtx.valid), .in_ready(vtx.ready), .in_last(vtx.last_vertex),
	.out_valid(nrm.valid), .out_ready(nrm.ready), .status(nrm.face_status),
	.nx(nrm.normal_x), .ny(nrm.normal_y), .nz(nrm.normal_z)
);
